/* design/fisr_pkg.sv */
// Shared constants, types and helper functions for the inverse square root pipeline.
`timescale 1ns / 1ps
`default_nettype none
package fisr_pkg;

  localparam int unsigned NEWTON_STEPS = 2;
  localparam int unsigned MUL_LAT      = 6;
  localparam int unsigned ADD_LAT      = 4;
  localparam int unsigned STEP_LAT     = 3 * MUL_LAT + ADD_LAT;
  localparam int unsigned X_TAP        = 2 * MUL_LAT + ADD_LAT;

  localparam logic [63:0] MAGIC_GUESS  = 64'h5FE6EB50C7B537A9;
  localparam logic [63:0] ONE_HALF     = 64'h3FE0000000000000;
  localparam logic [63:0] THREE_HALVES = 64'h3FF8000000000000;
  localparam logic [63:0] QNAN         = 64'h7FF8000000000000;
  localparam logic [10:0] EXP_ALL1     = 11'h7FF;

  typedef struct packed {
    logic        vld;
    logic        op;
    logic        rej;
    logic [63:0] v;
    logic [63:0] h;
  } side_t;

  function automatic logic [5:0] lzc53(input logic [52:0] m);
    logic [5:0] n;
    logic       found;
    n     = 6'd53;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 6'(52 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc56(input logic [55:0] m);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* design/fisr_fmul.sv */
// Six-stage double-precision multiplier, round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module fisr_fmul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] p_o
);

  localparam logic [10:0] EXP_ALL1_L = fisr_pkg::EXP_ALL1;

  // stage 1: unpack, leading zero count
  logic [10:0] ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        s1_sgn_q, s1_nan_q, s1_inf_q, s1_zero_q;
  logic [52:0] s1_ma_q, s1_mb_q;
  logic [12:0] s1_ea_q, s1_eb_q;
  logic [5:0]  s1_lza_q, s1_lzb_q;

  assign ea     = a_i[62:52];
  assign eb     = b_i[62:52];
  assign a_nan  = (ea == EXP_ALL1_L) && (a_i[51:0] != '0);
  assign b_nan  = (eb == EXP_ALL1_L) && (b_i[51:0] != '0);
  assign a_inf  = (ea == EXP_ALL1_L) && (a_i[51:0] == '0);
  assign b_inf  = (eb == EXP_ALL1_L) && (b_i[51:0] == '0);
  assign a_zero = (a_i[62:0] == '0);
  assign b_zero = (b_i[62:0] == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sgn_q  <= a_i[63] ^ b_i[63];
      s1_nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf_q  <= a_inf | b_inf;
      s1_zero_q <= a_zero | b_zero;
      s1_ma_q   <= {ea != '0, a_i[51:0]};
      s1_mb_q   <= {eb != '0, b_i[51:0]};
      s1_ea_q   <= {2'b00, (ea == '0) ? 11'd1 : ea};
      s1_eb_q   <= {2'b00, (eb == '0) ? 11'd1 : eb};
      s1_lza_q  <= fisr_pkg::lzc53({ea != '0, a_i[51:0]});
      s1_lzb_q  <= fisr_pkg::lzc53({eb != '0, b_i[51:0]});
    end
  end

  // stage 2: normalize operands, exponent sum
  logic               s2_sgn_q, s2_nan_q, s2_inf_q, s2_zero_q;
  logic        [52:0] s2_ma_q, s2_mb_q;
  logic signed [12:0] s2_e_q;
  logic signed [12:0] e2;

  assign e2 = $signed(s1_ea_q) - $signed({7'b0, s1_lza_q}) + $signed(s1_eb_q)
            - $signed({7'b0, s1_lzb_q}) - 13'sd1023;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sgn_q  <= s1_sgn_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= s1_zero_q;
      s2_ma_q   <= s1_ma_q << s1_lza_q;
      s2_mb_q   <= s1_mb_q << s1_lzb_q;
      s2_e_q    <= e2;
    end
  end

  // stage 3: partial products
  logic               s3_sgn_q, s3_nan_q, s3_inf_q, s3_zero_q;
  logic signed [12:0] s3_e_q;
  logic        [53:0] s3_hh_q;
  logic        [52:0] s3_hl_q, s3_lh_q;
  logic        [51:0] s3_ll_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sgn_q  <= s2_sgn_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_zero_q <= s2_zero_q;
      s3_e_q    <= s2_e_q;
      s3_hh_q   <= s2_ma_q[52:26] * s2_mb_q[52:26];
      s3_hl_q   <= s2_ma_q[52:26] * s2_mb_q[25:0];
      s3_lh_q   <= s2_ma_q[25:0] * s2_mb_q[52:26];
      s3_ll_q   <= s2_ma_q[25:0] * s2_mb_q[25:0];
    end
  end

  // stage 4: sum partial products
  logic               s4_sgn_q, s4_nan_q, s4_inf_q, s4_zero_q;
  logic signed [12:0] s4_e_q;
  logic       [105:0] s4_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sgn_q  <= s3_sgn_q;
      s4_nan_q  <= s3_nan_q;
      s4_inf_q  <= s3_inf_q;
      s4_zero_q <= s3_zero_q;
      s4_e_q    <= s3_e_q;
      s4_p_q    <= {s3_hh_q, 52'b0} + {27'b0, s3_hl_q, 26'b0}
                 + {27'b0, s3_lh_q, 26'b0} + {54'b0, s3_ll_q};
    end
  end

  // stage 5: normalize, denormal shift
  logic       [105:0] pn, psh;
  logic signed [12:0] er, shv;
  logic         [6:0] shc;
  logic               lost;
  logic        [52:0] mant5;
  logic               g5, st5, ovf5;
  logic        [10:0] ef5;

  always_comb begin
    pn   = s4_p_q[105] ? s4_p_q : (s4_p_q << 1);
    er   = s4_e_q + $signed({12'b0, s4_p_q[105]});
    shv  = 13'sd1 - er;
    shc  = (shv > 13'sd127) ? 7'd127 : shv[6:0];
    psh  = pn >> shc;
    lost = |(pn & ~({106{1'b1}} << shc));
    if (er > 13'sd0) begin
      mant5 = pn[105:53];
      g5    = pn[52];
      st5   = |pn[51:0];
      ef5   = er[10:0];
      ovf5  = (er >= 13'sd2047);
    end else begin
      mant5 = psh[105:53];
      g5    = psh[52];
      st5   = (|psh[51:0]) | lost;
      ef5   = '0;
      ovf5  = 1'b0;
    end
  end

  logic        s5_sgn_q, s5_nan_q, s5_inf_q, s5_zero_q, s5_ovf_q, s5_g_q, s5_st_q;
  logic [52:0] s5_m_q;
  logic [10:0] s5_ef_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sgn_q  <= s4_sgn_q;
      s5_nan_q  <= s4_nan_q;
      s5_inf_q  <= s4_inf_q;
      s5_zero_q <= s4_zero_q;
      s5_ovf_q  <= ovf5;
      s5_g_q    <= g5;
      s5_st_q   <= st5;
      s5_m_q    <= mant5;
      s5_ef_q   <= ef5;
    end
  end

  // stage 6: round and pack
  logic        rup;
  logic [62:0] mag;
  logic [63:0] p_d, p_q;

  always_comb begin
    rup = s5_g_q & (s5_st_q | s5_m_q[0]);
    mag = {s5_ef_q, s5_m_q[51:0]} + 63'(rup);
    if (s5_nan_q) begin
      p_d = fisr_pkg::QNAN;
    end else if (s5_inf_q || s5_ovf_q) begin
      p_d = {s5_sgn_q, EXP_ALL1_L, 52'b0};
    end else if (s5_zero_q) begin
      p_d = {s5_sgn_q, 63'b0};
    end else begin
      p_d = {s5_sgn_q, mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* design/fisr_fadd.sv */
// Four-stage double-precision adder, round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module fisr_fadd (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] s_o
);

  localparam logic [10:0] EXP_ALL1_L = fisr_pkg::EXP_ALL1;

  // stage 1: unpack, order by magnitude
  logic [10:0] ea, eb, ex, ey, d;
  logic        a_nan, b_nan, a_inf, b_inf, a_big, eff_sub;
  logic [63:0] xb, yb;

  always_comb begin
    ea      = a_i[62:52];
    eb      = b_i[62:52];
    a_nan   = (ea == EXP_ALL1_L) && (a_i[51:0] != '0);
    b_nan   = (eb == EXP_ALL1_L) && (b_i[51:0] != '0);
    a_inf   = (ea == EXP_ALL1_L) && (a_i[51:0] == '0);
    b_inf   = (eb == EXP_ALL1_L) && (b_i[51:0] == '0);
    eff_sub = a_i[63] ^ b_i[63];
    a_big   = (a_i[62:0] >= b_i[62:0]);
    xb      = a_big ? a_i : b_i;
    yb      = a_big ? b_i : a_i;
    ex      = (xb[62:52] == '0) ? 11'd1 : xb[62:52];
    ey      = (yb[62:52] == '0) ? 11'd1 : yb[62:52];
    d       = ex - ey;
  end

  logic        s1_sub_q, s1_sgn_q, s1_nan_q, s1_inf_q, s1_isgn_q;
  logic [52:0] s1_mx_q, s1_my_q;
  logic [10:0] s1_ex_q;
  logic [5:0]  s1_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sub_q  <= eff_sub;
      s1_sgn_q  <= xb[63];
      s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & eff_sub);
      s1_inf_q  <= a_inf | b_inf;
      s1_isgn_q <= a_inf ? a_i[63] : b_i[63];
      s1_mx_q   <= {xb[62:52] != '0, xb[51:0]};
      s1_my_q   <= {yb[62:52] != '0, yb[51:0]};
      s1_ex_q   <= ex;
      s1_d_q    <= (d > 11'd63) ? 6'd63 : d[5:0];
    end
  end

  // stage 2: align and add
  logic [55:0] xe, ye, ys, ya;
  logic        lost;
  logic [56:0] sum;

  always_comb begin
    xe   = {s1_mx_q, 3'b0};
    ye   = {s1_my_q, 3'b0};
    ys   = ye >> s1_d_q;
    lost = |(ye & ~({56{1'b1}} << s1_d_q));
    ya   = {ys[55:1], ys[0] | lost};
    sum  = s1_sub_q ? ({1'b0, xe} - {1'b0, ya}) : ({1'b0, xe} + {1'b0, ya});
  end

  logic        s2_sgn_q, s2_nan_q, s2_inf_q, s2_isgn_q;
  logic [10:0] s2_ex_q;
  logic [56:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sgn_q  <= s1_sgn_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_isgn_q <= s1_isgn_q;
      s2_ex_q   <= s1_ex_q;
      s2_sum_q  <= sum;
    end
  end

  // stage 3: normalize
  logic [5:0]  lz, sh;
  logic [11:0] lim, e3;
  logic [55:0] n3;

  always_comb begin
    lz  = fisr_pkg::lzc56(s2_sum_q[55:0]);
    lim = {1'b0, s2_ex_q} - 12'd1;
    sh  = ({6'b0, lz} < lim) ? lz : lim[5:0];
    if (s2_sum_q[56]) begin
      n3 = {s2_sum_q[56:2], s2_sum_q[1] | s2_sum_q[0]};
      e3 = {1'b0, s2_ex_q} + 12'd1;
    end else begin
      n3 = s2_sum_q[55:0] << sh;
      e3 = {1'b0, s2_ex_q} - {6'b0, sh};
    end
  end

  logic        s3_sgn_q, s3_nan_q, s3_inf_q, s3_isgn_q, s3_zero_q;
  logic [55:0] s3_n_q;
  logic [11:0] s3_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sgn_q  <= s2_sgn_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_isgn_q <= s2_isgn_q;
      s3_zero_q <= (s2_sum_q == '0);
      s3_n_q    <= n3;
      s3_e_q    <= e3;
    end
  end

  // stage 4: round and pack
  logic        rup;
  logic [10:0] ef;
  logic [62:0] mag;
  logic [63:0] s_d, s_q;

  always_comb begin
    rup = s3_n_q[2] & ((|s3_n_q[1:0]) | s3_n_q[3]);
    ef  = s3_n_q[55] ? s3_e_q[10:0] : 11'd0;
    mag = {ef, s3_n_q[54:3]} + 63'(rup);
    if (s3_nan_q) begin
      s_d = fisr_pkg::QNAN;
    end else if (s3_inf_q) begin
      s_d = {s3_isgn_q, EXP_ALL1_L, 52'b0};
    end else if (s3_e_q >= 12'd2047) begin
      s_d = {s3_sgn_q, EXP_ALL1_L, 52'b0};
    end else if (s3_zero_q) begin
      s_d = '0;
    end else begin
      s_d = {s3_sgn_q, mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;

endmodule
`default_nettype wire

/* design/fisr_newton.sv */
// One Newton refinement step x*(1.5 - (h*x)*x) with its side-band delay lines.
`timescale 1ns / 1ps
`default_nettype none
module fisr_newton (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire fisr_pkg::side_t side_i,
  input  wire logic     [63:0] x_i,
  output fisr_pkg::side_t      side_o,
  output logic          [63:0] x_o
);

  fisr_pkg::side_t sd_q [fisr_pkg::STEP_LAT];
  logic [63:0]     xd_q [fisr_pkg::X_TAP];
  logic [63:0]     t1, t2, s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fisr_pkg::STEP_LAT; i++) sd_q[i] <= '0;
    end else if (en_i) begin
      sd_q[0] <= side_i;
      for (int i = 1; i < fisr_pkg::STEP_LAT; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xd_q[0] <= x_i;
      for (int i = 1; i < fisr_pkg::X_TAP; i++) xd_q[i] <= xd_q[i-1];
    end
  end

  fisr_fmul u_mul_hx (
    .clk_i (clk_i), .en_i (en_i), .a_i (side_i.h), .b_i (x_i), .p_o (t1)
  );

  fisr_fmul u_mul_tx (
    .clk_i (clk_i), .en_i (en_i), .a_i (t1), .b_i (xd_q[fisr_pkg::MUL_LAT-1]), .p_o (t2)
  );

  fisr_fadd u_sub (
    .clk_i (clk_i), .en_i (en_i), .a_i (fisr_pkg::THREE_HALVES),
    .b_i ({~t2[63], t2[62:0]}), .s_o (s)
  );

  fisr_fmul u_mul_xs (
    .clk_i (clk_i), .en_i (en_i), .a_i (xd_q[fisr_pkg::X_TAP-1]), .b_i (s), .p_o (x_o)
  );

  assign side_o = sd_q[fisr_pkg::STEP_LAT-1];

endmodule
`default_nettype wire

/* design/fast_inverse_square_root_double.sv */
// Top level: pipelined double-precision inverse square root / square root.
//
// Input beat on s_axis: tdata carries the operand as IEEE-754 double bits,
// tuser[0] selects the function (0 inverse square root, 1 square root).
// Output beat on m_axis: tdata carries the result as double bits.
// NaN, infinity, zero and negative operands give +0.0.
// The seed is a magic constant minus the operand bits shifted right by one,
// refined by two Newton steps; every operation is a rounded double op.
// An accepted beat passes the input register, the chain of 8 six-stage
// multipliers and 2 four-stage adders, and the output register before its
// result beat is valid.
// Throughput: one beat per cycle with the skid empty; every stage advances together.
// When m_axis stalls, one more result is caught in a skid register and
// s_axis_tready drops while it is occupied; nothing is lost or repeated.
// Reset clears all valid bits, the output and the skid register; the block
// is ready for a beat in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module fast_inverse_square_root_double (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] value_bits
  input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata    // [63:0] result_bits
);

  logic en;
  logic skid_vld_q, out_vld_q;
  logic [63:0] skid_q, out_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // seed stage
  fisr_pkg::side_t s0_q;
  logic [63:0]     x0_q;
  logic            rej;

  assign rej = (s_axis_tdata[62:52] == fisr_pkg::EXP_ALL1) || s_axis_tdata[63]
            || (s_axis_tdata[62:0] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en) begin
      s0_q.vld <= s_axis_tvalid;
      s0_q.op  <= s_axis_tuser[0];
      s0_q.rej <= rej;
      s0_q.v   <= s_axis_tdata;
      s0_q.h   <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= fisr_pkg::MAGIC_GUESS - {1'b0, s_axis_tdata[63:1]};
    end
  end

  // half operand
  fisr_pkg::side_t hd_q [fisr_pkg::MUL_LAT];
  logic [63:0]     xh_q [fisr_pkg::MUL_LAT];
  logic [63:0]     h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fisr_pkg::MUL_LAT; i++) hd_q[i] <= '0;
    end else if (en) begin
      hd_q[0] <= s0_q;
      for (int i = 1; i < fisr_pkg::MUL_LAT; i++) hd_q[i] <= hd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xh_q[0] <= x0_q;
      for (int i = 1; i < fisr_pkg::MUL_LAT; i++) xh_q[i] <= xh_q[i-1];
    end
  end

  fisr_fmul u_mul_half (
    .clk_i (clk_i), .en_i (en), .a_i (s0_q.v), .b_i (fisr_pkg::ONE_HALF), .p_o (h)
  );

  // Newton chain
  fisr_pkg::side_t side_w [fisr_pkg::NEWTON_STEPS+1];
  logic [63:0]     x_w    [fisr_pkg::NEWTON_STEPS+1];
  fisr_pkg::side_t side0;

  always_comb begin
    side0   = hd_q[fisr_pkg::MUL_LAT-1];
    side0.h = h;
  end
  assign side_w[0] = side0;
  assign x_w[0]    = xh_q[fisr_pkg::MUL_LAT-1];

  for (genvar g = 0; g < fisr_pkg::NEWTON_STEPS; g++) begin : g_step
    fisr_newton u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_w[g]),
      .x_i    (x_w[g]),
      .side_o (side_w[g+1]),
      .x_o    (x_w[g+1])
    );
  end

  // square root product
  fisr_pkg::side_t fd_q [fisr_pkg::MUL_LAT];
  logic [63:0]     fx_q [fisr_pkg::MUL_LAT];
  logic [63:0]     prod, res;
  fisr_pkg::side_t fin;
  logic            emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fisr_pkg::MUL_LAT; i++) fd_q[i] <= '0;
    end else if (en) begin
      fd_q[0] <= side_w[fisr_pkg::NEWTON_STEPS];
      for (int i = 1; i < fisr_pkg::MUL_LAT; i++) fd_q[i] <= fd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q[0] <= x_w[fisr_pkg::NEWTON_STEPS];
      for (int i = 1; i < fisr_pkg::MUL_LAT; i++) fx_q[i] <= fx_q[i-1];
    end
  end

  fisr_fmul u_mul_root (
    .clk_i (clk_i), .en_i (en), .a_i (side_w[fisr_pkg::NEWTON_STEPS].v),
    .b_i (x_w[fisr_pkg::NEWTON_STEPS]), .p_o (prod)
  );

  assign fin  = fd_q[fisr_pkg::MUL_LAT-1];
  assign res  = fin.rej ? 64'd0 : (fin.op ? prod : fx_q[fisr_pkg::MUL_LAT-1]);
  assign emit = en && fin.vld;

  // output register and skid
  logic pop;
  assign pop = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
      out_q      <= '0;
      skid_q     <= '0;
    end else if (skid_vld_q) begin
      if (pop) begin
        out_q      <= skid_q;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_q <= emit;
      out_q     <= res;
    end else if (emit) begin
      skid_q     <= res;
      skid_vld_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire
